// ===== hdl/ffsa_pkg.sv =====
`default_nettype none
package ffsa_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned UnitW       = 16;
  localparam int unsigned GapW        = UnitW + 2;
  localparam logic [UnitW-1:0] TotalUnitsReset = UnitW'(500);

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_COMPACT = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_NO_SPACE  = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUP_RD,
    ST_DUP_CHK,
    ST_GAP_RD,
    ST_GAP_CHK,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_INS,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [UnitW-1:0]  owner_id;
    logic [UnitW-1:0]  request_size;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [UnitW-1:0]  placed_offset;
    logic [CntW-1:0]   entries_used;
  } res_t;

  typedef struct packed {
    logic [UnitW-1:0]  owner_id;
    logic [UnitW-1:0]  offset;
    logic [UnitW-1:0]  length;
    logic              in_use;
  } seg_t;

  localparam int unsigned SegW = $bits(seg_t);

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    seg_t             wdata;
    logic [IdxW-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// ===== hdl/ffsa_ram.sv =====
`default_nettype none
module ffsa_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 49
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/ffsa_ctrl.sv =====
`default_nettype none
module ffsa_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire ffsa_pkg::cmd_t                cmd_i,
  input  wire logic [ffsa_pkg::UnitW-1:0]    total_units_i,
  output ffsa_pkg::res_t                     res_o,
  output logic                               done_o,
  output ffsa_pkg::ram_req_t                 ram_o,
  input  wire logic [ffsa_pkg::SegW-1:0]     rdata_i
);
  import ffsa_pkg::*;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CntW-1:0]   idx_q, idx_d, pos_q, pos_d, kept_q, kept_d, count_q, count_d;
  logic [UnitW:0]    cursor_q, cursor_d;
  logic [UnitW-1:0]  base_q, base_d, placed_q, placed_d;
  status_e           status_q, status_d;

  seg_t              ent, upd;
  logic [UnitW-1:0]  sub_a;
  logic signed [GapW-1:0] gap;
  logic              fit, match;
  logic [CntW-1:0]   idx_m1;

  assign ent    = seg_t'(rdata_i);
  assign match  = ent.in_use && (ent.owner_id == cmd_q.owner_id);
  assign idx_m1 = idx_q - CntW'(1);

  // shared gap unit
  always_comb begin
    sub_a = (state_q == ST_GAP_RD) ? total_units_i : ent.offset;
    gap   = $signed({2'b00, sub_a}) - $signed({1'b0, cursor_q});
    fit   = gap >= $signed({2'b00, cmd_q.request_size});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    kept_q   <= kept_d;
    cursor_q <= cursor_d;
    base_q   <= base_d;
    placed_q <= placed_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    kept_d   = kept_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    base_d   = base_q;
    placed_d = placed_q;
    status_d = status_q;
    upd      = ent;
    ram_o.we    = 1'b0;
    ram_o.waddr = idx_q[IdxW-1:0];
    ram_o.wdata = ent;
    ram_o.raddr = idx_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          idx_d    = '0;
          status_d = STS_OK;
          placed_d = '0;
          case (cmd_i.mode)
            MODE_ALLOC:   state_d = ST_DUP_RD;
            MODE_FREE:    state_d = ST_FREE_RD;
            MODE_COMPACT: begin
              kept_d  = '0;
              base_d  = '0;
              state_d = ST_CMP_RD;
            end
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_DUP_RD: begin
        if (idx_q == count_q) begin
          if (count_q == CntW'(MaxSegments)) begin
            status_d = STS_FULL;
            state_d  = ST_DONE;
          end else begin
            idx_d    = '0;
            cursor_d = '0;
            state_d  = ST_GAP_RD;
          end
        end else begin
          state_d = ST_DUP_CHK;
        end
      end
      ST_DUP_CHK: begin
        if (match) begin
          status_d = STS_DUPLICATE;
          state_d  = ST_DONE;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_DUP_RD;
        end
      end
      ST_GAP_RD: begin
        if (idx_q == count_q) begin
          if (fit) begin
            pos_d   = idx_q;
            state_d = ST_SHF_RD;
          end else begin
            status_d = STS_NO_SPACE;
            state_d  = ST_DONE;
          end
        end else begin
          state_d = ST_GAP_CHK;
        end
      end
      ST_GAP_CHK: begin
        if (fit) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = ST_SHF_RD;
        end else begin
          cursor_d = {1'b0, ent.offset} + {1'b0, ent.length};
          idx_d    = idx_q + CntW'(1);
          state_d  = ST_GAP_RD;
        end
      end
      ST_SHF_RD: begin
        ram_o.raddr = idx_m1[IdxW-1:0];
        if (idx_q == pos_q) begin
          state_d = ST_INS;
        end else begin
          state_d = ST_SHF_WR;
        end
      end
      ST_SHF_WR: begin
        ram_o.we = 1'b1;
        idx_d    = idx_m1;
        state_d  = ST_SHF_RD;
      end
      ST_INS: begin
        upd.owner_id = cmd_q.owner_id;
        upd.offset   = cursor_q[UnitW-1:0];
        upd.length   = cmd_q.request_size;
        upd.in_use   = 1'b1;
        ram_o.we     = 1'b1;
        ram_o.waddr  = pos_q[IdxW-1:0];
        ram_o.wdata  = upd;
        count_d      = count_q + CntW'(1);
        placed_d     = cursor_q[UnitW-1:0];
        state_d      = ST_DONE;
      end
      ST_FREE_RD: begin
        if (idx_q == count_q) begin
          status_d = STS_NOT_FOUND;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_FREE_CHK;
        end
      end
      ST_FREE_CHK: begin
        if (match) begin
          upd.in_use  = 1'b0;
          ram_o.we    = 1'b1;
          ram_o.wdata = upd;
          state_d     = ST_DONE;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_FREE_RD;
        end
      end
      ST_CMP_RD: begin
        if (idx_q == count_q) begin
          count_d = kept_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (ent.in_use) begin
          upd.offset  = base_q;
          ram_o.we    = 1'b1;
          ram_o.waddr = kept_q[IdxW-1:0];
          ram_o.wdata = upd;
          base_d      = base_q + ent.length;
          kept_d      = kept_q + CntW'(1);
        end
        idx_d   = idx_q + CntW'(1);
        state_d = ST_CMP_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o              = state_q != ST_IDLE;
  assign done_o              = state_q == ST_DONE;
  assign res_o.status        = status_q;
  assign res_o.placed_offset = placed_q;
  assign res_o.entries_used  = count_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSegments))
    else $error("entry count out of range");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result beat not single");
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> busy_o)
    else $error("table write while idle");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q) == ST_INS || $past(state_q) == ST_CMP_RD)
    else $error("entry count changed outside insert or compact");
`endif

endmodule
`default_nettype wire

// ===== hdl/first_fit_segment_allocator_unit.sv =====
`default_nettype none
// First-fit segment allocator. A command is taken when start is high and busy is low; busy
// then stays high until the result beat, which is shown on res_o for one cycle with done_o
// and cannot be held off. Allocate, free and compact commands walk the offset-ordered
// segment table, held in a memory with one write port and one registered read port.
// Allocate runs an id check pass, a gap search, then shifts the tail up one slot; with a
// full table of 64 it stops after the id check. A no-op command goes straight to done.
// The user must write total_units over cfg_* only while busy is low; the block itself
// leaves this unenforced, and cfg_ready_o is tied high.
module first_fit_segment_allocator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ffsa_pkg::cmd_t             cmd_i,
  output ffsa_pkg::res_t                  res_o,
  output logic                            done_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [ffsa_pkg::UnitW-1:0] cfg_data_i
);
  import ffsa_pkg::*;

  logic [UnitW-1:0] total_units_q;
  ram_req_t         ram_req;
  logic [SegW-1:0]  rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_units_q <= TotalUnitsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_units_q <= cfg_data_i;
    end
  end

  ffsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .cmd_i         (cmd_i),
    .total_units_i (total_units_q),
    .res_o         (res_o),
    .done_o        (done_o),
    .ram_o         (ram_req),
    .rdata_i       (rdata)
  );

  ffsa_ram #(
    .Depth (MaxSegments),
    .Width (SegW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

endmodule
`default_nettype wire

// ===== tb/first_fit_segment_allocator_unit_tb.sv =====
`default_nettype none
module first_fit_segment_allocator_unit_tb;
  import ffsa_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  res_t res_o;
  logic done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [UnitW-1:0] cfg_data_i = '0;

  first_fit_segment_allocator_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .res_o(res_o),
    .done_o(done_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // allocator shadow state
  seg_t segs[MaxSegments];
  int unsigned seg_count = 0;
  logic [UnitW-1:0] mem_units = TotalUnitsReset;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int idle_pct = 0;
  bit cmd_taken = 1'b0;
  int cfg_beats = 0;
  int quiet_cycles = 0;
  bit failed = 1'b0;

  function automatic res_t allocate(logic [UnitW-1:0] id, logic [UnitW-1:0] size);
    res_t r;
    int cursor;
    int gap;
    r = '0;
    r.status = STS_OK;
    for (int i = 0; i < seg_count; i++) begin
      if (segs[i].in_use && segs[i].owner_id == id) begin
        r.status = STS_DUPLICATE;
        return r;
      end
    end
    if (seg_count >= MaxSegments) begin
      r.status = STS_FULL;
      return r;
    end
    cursor = 0;
    for (int i = 0; i <= seg_count; i++) begin
      if (i == seg_count) gap = int'(mem_units) - cursor;
      else gap = int'(segs[i].offset) - cursor;
      if (gap >= int'(size)) begin
        for (int j = seg_count; j > i; j--) segs[j] = segs[j-1];
        segs[i].owner_id = id;
        segs[i].offset = UnitW'(cursor);
        segs[i].length = size;
        segs[i].in_use = 1'b1;
        seg_count++;
        r.placed_offset = UnitW'(cursor);
        return r;
      end
      if (i < seg_count) cursor = int'(segs[i].offset) + int'(segs[i].length);
    end
    r.status = STS_NO_SPACE;
    return r;
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    int unsigned kept;
    int base;
    r = '0;
    r.status = STS_OK;
    case (c.mode)
      MODE_ALLOC: begin
        r = allocate(c.owner_id, c.request_size);
      end
      MODE_FREE: begin
        r.status = STS_NOT_FOUND;
        for (int i = 0; i < seg_count; i++) begin
          if (segs[i].in_use && segs[i].owner_id == c.owner_id) begin
            segs[i].in_use = 1'b0;
            r.status = STS_OK;
            break;
          end
        end
      end
      MODE_COMPACT: begin
        kept = 0;
        base = 0;
        for (int i = 0; i < seg_count; i++) begin
          if (segs[i].in_use) begin
            segs[kept] = segs[i];
            segs[kept].offset = UnitW'(base);
            base += int'(segs[i].length);
            kept++;
          end
        end
        seg_count = kept;
      end
      default: ;
    endcase
    r.entries_used = CntW'(seg_count);
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || cmd_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          cmd_i <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      cmd_taken = start && !busy;
      if (cmd_taken) expected_res.push_back(apply_cmd(cmd_i));
      if (cfg_valid_i && cfg_ready_o) begin
        mem_units = cfg_data_i;
        cfg_beats++;
      end
      if (done_o) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, res_o);
          failed = 1'b1;
        end else begin
          exp_r = expected_res.pop_front();
          if (res_o.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, res_o.status);
            failed = 1'b1;
          end
          if (res_o.placed_offset !== exp_r.placed_offset) begin
            $display("%0t: placed_offset expected %0d actual %0d", $time,
                     exp_r.placed_offset, res_o.placed_offset);
            failed = 1'b1;
          end
          if (res_o.entries_used !== exp_r.entries_used) begin
            $display("%0t: entries_used expected %0d actual %0d", $time,
                     exp_r.entries_used, res_o.entries_used);
            failed = 1'b1;
          end
        end
      end
      if (cmd_taken || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(mode_e m, logic [UnitW-1:0] id, logic [UnitW-1:0] size);
    cmd_t c;
    c.mode = m;
    c.owner_id = id;
    c.request_size = size;
    return c;
  endfunction

  function automatic cmd_t random_cmd(int max_size);
    int pick;
    mode_e m;
    logic [UnitW-1:0] id;
    logic [UnitW-1:0] size;
    pick = $urandom_range(99);
    if (pick < 55) m = MODE_ALLOC;
    else if (pick < 88) m = MODE_FREE;
    else if (pick < 97) m = MODE_COMPACT;
    else m = mode_e'(2'd3);
    id = ($urandom_range(9) == 0) ? UnitW'($urandom) : UnitW'($urandom_range(40));
    pick = $urandom_range(19);
    if (pick == 0) size = UnitW'($urandom);
    else if (pick < 3) size = '0;
    else size = UnitW'($urandom_range(max_size));
    return make_cmd(m, id, size);
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_res.size() > 0 || start) @(negedge clk_i);
  endtask

  task automatic write_units(logic [UnitW-1:0] units);
    int seen;
    drain();
    seen = cfg_beats;
    cfg_valid_i <= 1'b1;
    cfg_data_i <= units;
    while (cfg_beats == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n, int max_size);
    repeat (n) pending_cmds.push_back(random_cmd(max_size));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 14;
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'h0000, 16'd5));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'hFFFF, 16'd500));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'h1234, 16'd1));
    pending_cmds.push_back(make_cmd(MODE_FREE, 16'h5555, 16'hFFFF));
    pending_cmds.push_back(make_cmd(MODE_FREE, 16'hFFFF, 16'h0000));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'hAAAA, 16'd100));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'hFFFF, 16'd100));
    pending_cmds.push_back(make_cmd(MODE_FREE, 16'hFFFF, 16'h0000));
    pending_cmds.push_back(make_cmd(MODE_FREE, 16'hFFFF, 16'h0000));
    pending_cmds.push_back(make_cmd(mode_e'(2'd3), 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(MODE_COMPACT, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(MODE_ALLOC, 16'h0001, 16'd400));
    pending_cmds.push_back(make_cmd(MODE_COMPACT, 16'hFFFF, 16'hFFFF));
    run_random(120, 12);

    // tiny memory
    write_units(16'd1);
    run_random(60, 2);

    // large memory, table fills up
    idle_pct = 56;
    write_units(16'hFFFF);
    for (int i = 0; i < 70; i++)
      pending_cmds.push_back(make_cmd(MODE_ALLOC, UnitW'(100 + i), UnitW'($urandom_range(30))));
    run_random(160, 300);

    // shrink below the end of the table
    write_units(16'd40);
    run_random(120, 8);

    idle_pct = 0;
    write_units(TotalUnitsReset);
    run_random(150, 20);

    write_units(UnitW'($urandom_range(1, 65535)));
    run_random(100, 1000);

    drain();
    repeat (50) @(negedge clk_i);
    if (!failed && expected_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== first_fit_segment_allocator_unit.f =====
hdl/ffsa_pkg.sv
hdl/ffsa_ram.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator_unit.sv
tb/first_fit_segment_allocator_unit_tb.sv
